// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, masked while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/hkgm_pkg.sv
// ----------------------------------------------------------------------------
// hkgm_pkg
// Types, constants and the keycode table of the keyboard to gamepad decoder.
// ----------------------------------------------------------------------------
package hkgm_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int BUTTONS   = 26;

    typedef logic [7:0]         t_keycode;
    typedef logic [4:0]         t_button;
    typedef logic [BUTTONS-1:0] t_mask;
    typedef logic [1:0]         t_led;

    localparam t_keycode KEY_NONE   = 8'd0;
    localparam t_keycode KEY_CAPS   = 8'd57;
    localparam t_keycode SHIFT_BITS = 8'h22;
    localparam t_button  NO_BUTTON  = 5'd31;
    localparam t_led     LED_CAPS   = 2'd2;
    localparam t_led     LED_OFF    = 2'd0;

    function automatic t_button key_button(input t_keycode code, input logic shift);
        t_button plain;
        t_button shifted;
        plain   = NO_BUTTON;
        shifted = NO_BUTTON;
        unique case (code)
            8'd4:  begin plain = 5'd2;  shifted = 5'd16; end
            8'd7:  begin plain = 5'd3;  shifted = 5'd17; end
            8'd8:  begin plain = 5'd9;  shifted = 5'd9;  end
            8'd11: begin plain = 5'd14; shifted = 5'd14; end
            8'd13: begin plain = 5'd12; shifted = 5'd12; end
            8'd14: begin plain = 5'd13; shifted = 5'd13; end
            8'd16: begin plain = 5'd7;  shifted = 5'd7;  end
            8'd17: begin plain = 5'd6;  shifted = 5'd6;  end
            8'd19: begin plain = 5'd10; shifted = 5'd10; end
            8'd20: begin plain = 5'd8;  shifted = 5'd8;  end
            8'd21: begin plain = 5'd25; shifted = 5'd25; end
            8'd22: begin plain = 5'd1;  shifted = 5'd19; end
            8'd24: begin plain = 5'd15; shifted = 5'd15; end
            8'd26: begin plain = 5'd0;  shifted = 5'd18; end
            8'd40: begin plain = 5'd4;  shifted = 5'd4;  end
            8'd42: begin plain = 5'd5;  shifted = 5'd5;  end
            8'd43: begin plain = 5'd24; shifted = 5'd24; end
            default: begin plain = NO_BUTTON; shifted = NO_BUTTON; end
        endcase
        return shift ? shifted : plain;
    endfunction

endpackage

// File: sv/hid_keyboard_to_gamepad_mask.sv
// ----------------------------------------------------------------------------
// hid_keyboard_to_gamepad_mask
// Decodes boot keyboard reports into a gamepad button mask and caps LED requests.
// ----------------------------------------------------------------------------
//  channel | valid        | ready        | payload
//  report  | i_in_valid   | o_in_ready   | modifier, six key slots, mask, address
//  result  | o_out_valid  | i_out_ready  | button mask, LED request fields
//
//  One report per cycle while the result is not stalled; a taken report moves through
//  the input register, then the result register.
//  Caps mode and the previous keys update as a report moves into the result register.
//  A stalled result holds; the input register still takes a report while it is empty.
//  Reset clears both valid flags, the previous keys and caps mode.
// ----------------------------------------------------------------------------
module hid_keyboard_to_gamepad_mask
    import hkgm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_modifier_bits,
    input  logic [7:0]  i_key_slot_0,
    input  logic [7:0]  i_key_slot_1,
    input  logic [7:0]  i_key_slot_2,
    input  logic [7:0]  i_key_slot_3,
    input  logic [7:0]  i_key_slot_4,
    input  logic [7:0]  i_key_slot_5,
    input  logic [25:0] i_prior_mask,
    input  logic [6:0]  i_dev_address,
    input  logic [3:0]  i_interface_instance,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [25:0] o_button_mask,
    output logic        o_led_request,
    output logic [1:0]  o_led_byte,
    output logic [6:0]  o_led_dev_address,
    output logic [3:0]  o_led_instance
);

    t_keycode w_keys [KEY_SLOTS];

    logic     r_s1_valid;
    t_keycode r_s1_mod;
    t_keycode r_s1_keys [KEY_SLOTS];
    t_mask    r_s1_mask;
    logic [6:0] r_s1_addr;
    logic [3:0] r_s1_inst;

    logic     r_out_valid;
    t_mask    r_button_mask;
    logic     r_led_request;
    t_led     r_led_byte;
    logic [6:0] r_led_addr;
    logic [3:0] r_led_inst;

    t_keycode r_prev_keys [KEY_SLOTS];
    logic     r_caps_mode;

    logic     w_in_acc;
    logic     w_s1_adv;
    logic     w_caps_held;
    logic     w_shift_mod;
    logic     n_caps_mode;
    logic     n_led_request;
    t_mask    n_button_mask;
    t_button  w_btn;

    assign w_keys[0] = i_key_slot_0;
    assign w_keys[1] = i_key_slot_1;
    assign w_keys[2] = i_key_slot_2;
    assign w_keys[3] = i_key_slot_3;
    assign w_keys[4] = i_key_slot_4;
    assign w_keys[5] = i_key_slot_5;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_shift_mod = |(r_s1_mod & SHIFT_BITS);

    always_comb begin
        w_caps_held = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (r_prev_keys[i] == KEY_CAPS) begin
                w_caps_held = 1'b1;
            end
        end
    end

    // walk slots in order: caps mode flips at each fresh Caps Lock slot, other keys set button bits
    always_comb begin
        n_caps_mode   = r_caps_mode;
        n_led_request = 1'b0;
        n_button_mask = r_s1_mask;
        w_btn         = NO_BUTTON;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (r_s1_keys[i] == KEY_CAPS) begin
                if (!w_caps_held) begin
                    n_caps_mode   = !n_caps_mode;
                    n_led_request = 1'b1;
                end
            end else if (r_s1_keys[i] != KEY_NONE) begin
                w_btn = key_button(r_s1_keys[i], w_shift_mod || n_caps_mode);
                if (w_btn < t_button'(BUTTONS)) begin
                    n_button_mask[w_btn] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_caps_mode <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_prev_keys[i] <= KEY_NONE;
            end
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
                r_caps_mode <= n_caps_mode;
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    r_prev_keys[i] <= r_s1_keys[i];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold payloads unless a beat moves in
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_mod  <= i_modifier_bits;
            r_s1_mask <= i_prior_mask;
            r_s1_addr <= i_dev_address;
            r_s1_inst <= i_interface_instance;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_s1_keys[i] <= w_keys[i];
            end
        end
        if (w_s1_adv) begin
            r_button_mask <= n_button_mask;
            r_led_request <= n_led_request;
            r_led_byte    <= (n_led_request && n_caps_mode) ? LED_CAPS : LED_OFF;
            r_led_addr    <= n_led_request ? r_s1_addr : 7'd0;
            r_led_inst    <= n_led_request ? r_s1_inst : 4'd0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_button_mask     = r_button_mask;
    assign o_led_request     = r_led_request;
    assign o_led_byte        = r_led_byte;
    assign o_led_dev_address = r_led_addr;
    assign o_led_instance    = r_led_inst;

endmodule

// File: sv/hkgm_checker.sv
// ----------------------------------------------------------------------------
// hkgm_checker
// Port-level checks on the keyboard to gamepad decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hkgm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [25:0] o_button_mask,
    input  logic        o_led_request,
    input  logic [1:0]  o_led_byte,
    input  logic [6:0]  o_led_dev_address,
    input  logic [3:0]  o_led_instance
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_button_mask) && $stable(o_led_request) && $stable(o_led_byte))

    `ASSERT_NOW(a_led_quiet, i_clk, i_rst_n, o_out_valid && !o_led_request, o_led_byte == 2'd0 && o_led_dev_address == 7'd0 && o_led_instance == 4'd0)

    `ASSERT_NOW(a_led_byte_code, i_clk, i_rst_n, o_out_valid, o_led_byte == 2'd0 || o_led_byte == 2'd2)

endmodule

bind hid_keyboard_to_gamepad_mask hkgm_checker u_hkgm_checker (.*);

// File: dv/hid_keyboard_to_gamepad_mask_test.sv
// ----------------------------------------------------------------------------
// hid_keyboard_to_gamepad_mask_test
// Sends boot keyboard reports to the decoder and checks every result beat
// against a local decode of the same report. Directed reports cover field
// extremes, the whole keycode table under both shift bits, keycodes past the
// table and the Caps Lock cases. Random reports follow, many of them held-key
// sequences, under three idling settings on both channels.
// ----------------------------------------------------------------------------
module hid_keyboard_to_gamepad_mask_test;
    import hkgm_pkg::*;

    typedef struct packed {
        t_keycode                  modifier;
        t_keycode [KEY_SLOTS-1:0]  keys;
        t_mask                     prior;
        logic [6:0]                addr;
        logic [3:0]                inst;
    } report_t;

    typedef struct packed {
        t_mask       mask;
        logic        led_req;
        t_led        led_byte;
        logic [6:0]  led_addr;
        logic [3:0]  led_inst;
    } pad_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_modifier_bits;
    logic [7:0]  i_key_slot_0;
    logic [7:0]  i_key_slot_1;
    logic [7:0]  i_key_slot_2;
    logic [7:0]  i_key_slot_3;
    logic [7:0]  i_key_slot_4;
    logic [7:0]  i_key_slot_5;
    logic [25:0] i_prior_mask;
    logic [6:0]  i_dev_address;
    logic [3:0]  i_interface_instance;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [25:0] o_button_mask;
    logic        o_led_request;
    logic [1:0]  o_led_byte;
    logic [6:0]  o_led_dev_address;
    logic [3:0]  o_led_instance;

    t_keycode [KEY_SLOTS-1:0] held_keys;
    logic                     caps_on;
    pad_result_t              pending_pads[$];
    report_t                  last_sent;
    int                       gap_pct;
    int                       stall_pct;
    int                       mismatches = 0;

    hid_keyboard_to_gamepad_mask dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_modifier_bits      (i_modifier_bits),
        .i_key_slot_0         (i_key_slot_0),
        .i_key_slot_1         (i_key_slot_1),
        .i_key_slot_2         (i_key_slot_2),
        .i_key_slot_3         (i_key_slot_3),
        .i_key_slot_4         (i_key_slot_4),
        .i_key_slot_5         (i_key_slot_5),
        .i_prior_mask         (i_prior_mask),
        .i_dev_address        (i_dev_address),
        .i_interface_instance (i_interface_instance),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_button_mask        (o_button_mask),
        .o_led_request        (o_led_request),
        .o_led_byte           (o_led_byte),
        .o_led_dev_address    (o_led_dev_address),
        .o_led_instance       (o_led_instance)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_button pad_button(input t_keycode code, input logic shifted);
        case (code)
            8'd4:    return shifted ? 5'd16 : 5'd2;
            8'd7:    return shifted ? 5'd17 : 5'd3;
            8'd8:    return 5'd9;
            8'd11:   return 5'd14;
            8'd13:   return 5'd12;
            8'd14:   return 5'd13;
            8'd16:   return 5'd7;
            8'd17:   return 5'd6;
            8'd19:   return 5'd10;
            8'd20:   return 5'd8;
            8'd21:   return 5'd25;
            8'd22:   return shifted ? 5'd19 : 5'd1;
            8'd24:   return 5'd15;
            8'd26:   return shifted ? 5'd18 : 5'd0;
            8'd40:   return 5'd4;
            8'd42:   return 5'd5;
            8'd43:   return 5'd24;
            default: return NO_BUTTON;
        endcase
    endfunction

    task automatic map_report(input report_t r, output pad_result_t res);
        t_mask    mask;
        logic     flipped;
        logic     held;
        logic     shifted;
        t_button  btn;
        t_keycode code;
        int       i;
        int       j;
        mask    = r.prior;
        flipped = 1'b0;
        for (i = 0; i < KEY_SLOTS; i++) begin
            code = r.keys[i];
            if (code == KEY_CAPS) begin
                held = 1'b0;
                for (j = 0; j < KEY_SLOTS; j++) begin
                    if (held_keys[j] == KEY_CAPS) held = 1'b1;
                end
                if (!held) begin
                    caps_on = ~caps_on;
                    flipped = 1'b1;
                end
            end else if (code != KEY_NONE) begin
                shifted = ((r.modifier & SHIFT_BITS) != 8'd0) || caps_on;
                btn     = pad_button(code, shifted);
                if (btn < BUTTONS) mask[btn] = 1'b1;
            end
        end
        held_keys    = r.keys;
        res.mask     = mask;
        res.led_req  = flipped;
        res.led_byte = (flipped && caps_on) ? LED_CAPS : LED_OFF;
        res.led_addr = flipped ? r.addr : 7'd0;
        res.led_inst = flipped ? r.inst : 4'd0;
    endtask

    function automatic report_t make_report(input t_keycode mod,
                                            input t_keycode k0, input t_keycode k1,
                                            input t_keycode k2, input t_keycode k3,
                                            input t_keycode k4, input t_keycode k5,
                                            input t_mask prior, input logic [6:0] addr,
                                            input logic [3:0] inst);
        report_t r;
        r.modifier = mod;
        r.keys     = {k5, k4, k3, k2, k1, k0};
        r.prior    = prior;
        r.addr     = addr;
        r.inst     = inst;
        return r;
    endfunction

    function automatic t_keycode random_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) return KEY_NONE;
        if (pick < 35) return KEY_CAPS;
        if (pick < 80) return t_keycode'($urandom_range(1, 45));
        if (pick < 90) return t_keycode'($urandom_range(136, 255));
        return t_keycode'($urandom_range(0, 255));
    endfunction

    // Held-key sequences in part: keep the last report and change one slot, else redraw all slots.
    function automatic report_t random_report(input report_t prev);
        report_t r;
        int      i;
        r = prev;
        if ($urandom_range(0, 99) < 45) begin
            r.keys[$urandom_range(0, KEY_SLOTS-1)] = random_key();
        end else begin
            for (i = 0; i < KEY_SLOTS; i++) r.keys[i] = random_key();
        end
        r.modifier = t_keycode'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0) r.modifier = r.modifier & SHIFT_BITS;
        r.prior = ($urandom_range(0, 2) == 0) ? t_mask'($urandom_range(0, 26'h3FFFFFF)) : '0;
        r.addr  = 7'($urandom_range(0, 127));
        r.inst  = 4'($urandom_range(0, 15));
        return r;
    endfunction

    task automatic send_report(input report_t r);
        pad_result_t want;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_modifier_bits      <= r.modifier;
        i_key_slot_0         <= r.keys[0];
        i_key_slot_1         <= r.keys[1];
        i_key_slot_2         <= r.keys[2];
        i_key_slot_3         <= r.keys[3];
        i_key_slot_4         <= r.keys[4];
        i_key_slot_5         <= r.keys[5];
        i_prior_mask         <= r.prior;
        i_dev_address        <= r.addr;
        i_interface_instance <= r.inst;
        do @(posedge i_clk); while (!o_in_ready);
        map_report(r, want);
        pending_pads.push_back(want);
        last_sent = r;
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_pads.size() != 0);
    endtask

    task automatic test_extremes();
        send_report(make_report(8'h00, 0, 0, 0, 0, 0, 0, '0, 7'd0, 4'd0));
        send_report(make_report(8'hFF, 255, 255, 255, 255, 255, 255, '1, 7'd127, 4'd15));
        send_report(make_report(8'h00, 135, 136, 200, 1, 2, 3, 26'h2AAAAAA, 7'd0, 4'd15));
        send_report(make_report(8'hDD, 4, 7, 8, 11, 13, 14, 26'h1555555, 7'd127, 4'd0));
    endtask

    task automatic test_keycode_table();
        t_keycode mod;
        int       m;
        for (m = 0; m < 3; m++) begin
            mod = (m == 1) ? 8'h02 : (m == 2) ? 8'h20 : 8'h00;
            send_report(make_report(mod, 4, 7, 8, 11, 13, 14, '0, 7'd1, 4'd1));
            send_report(make_report(mod, 16, 17, 19, 20, 21, 22, '0, 7'd2, 4'd2));
            send_report(make_report(mod, 24, 26, 40, 42, 43, 0, '0, 7'd3, 4'd3));
        end
    endtask

    task automatic test_caps_lock();
        send_report(make_report(8'h00, KEY_CAPS, 0, 0, 0, 0, 0, '0, 7'd5, 4'd3));
        send_report(make_report(8'h00, 4, KEY_CAPS, 0, 0, 0, 0, '0, 7'd6, 4'd4));
        send_report(make_report(8'h00, 0, 0, 0, 0, 0, 0, '0, 7'd7, 4'd5));
        send_report(make_report(8'h00, 22, KEY_CAPS, 26, 0, 0, 0, '0, 7'd99, 4'd9));
        send_report(make_report(8'h00, 0, 0, 0, 0, 0, 0, '0, 7'd8, 4'd6));
        send_report(make_report(8'h00, KEY_CAPS, 4, KEY_CAPS, 7, 0, 0, '0, 7'd77, 4'd12));
        send_report(make_report(8'h00, 0, 0, 0, 0, 0, KEY_CAPS, '0, 7'd9, 4'd7));
        send_report(make_report(8'h00, 0, 0, 0, 0, 0, 0, '0, 7'd10, 4'd8));
        send_report(make_report(8'h00, 0, 0, 0, 0, 26, KEY_CAPS, '0, 7'd127, 4'd15));
    endtask

    task automatic test_random_reports(input int total);
        int phase;
        int n;
        for (phase = 0; phase < 3; phase++) begin
            gap_pct   = (phase == 0) ? 11 : (phase == 1) ? 74 : 0;
            stall_pct = (phase == 0) ? 74 : (phase == 1) ? 11 : 0;
            for (n = 0; n < total / 3; n++) begin
                if (n == total / 6) wait_for_results();
                send_report(random_report(last_sent));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [25:0] want,
                               input logic [25:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        pad_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pads.size() == 0) begin
                $error("result beat with no report outstanding");
                mismatches++;
            end else begin
                want = pending_pads.pop_front();
                check_field("button_mask", want.mask, o_button_mask);
                check_field("led_request", 26'(want.led_req), 26'(o_led_request));
                check_field("led_byte", 26'(want.led_byte), 26'(o_led_byte));
                check_field("led_dev_address", 26'(want.led_addr),
                            26'(o_led_dev_address));
                check_field("led_instance", 26'(want.led_inst), 26'(o_led_instance));
            end
        end
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n              = 1'b0;
        i_in_valid           = 1'b0;
        i_modifier_bits      = '0;
        i_key_slot_0         = '0;
        i_key_slot_1         = '0;
        i_key_slot_2         = '0;
        i_key_slot_3         = '0;
        i_key_slot_4         = '0;
        i_key_slot_5         = '0;
        i_prior_mask         = '0;
        i_dev_address        = '0;
        i_interface_instance = '0;
        i_out_ready          = 1'b0;
        held_keys            = '0;
        caps_on              = 1'b0;
        last_sent            = '0;
        gap_pct              = 11;
        stall_pct            = 74;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_keycode_table();
        test_caps_lock();
        test_random_reports(1900);
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_pads.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
